// ===== hdl/sexpr_lex_pkg.sv =====
// Shared types and constants for the s-expression token lexer.
// Depends on nothing; the lexer core, the record queue and the top level import it.
package sexpr_lex_pkg;

    // Token codes. The sign code is internal only: a lone '+' or '-' that may
    // still become a number. It is reported as a symbol.
    typedef enum logic [2:0] {
        KIND_BLANK  = 3'd0,
        KIND_OPEN   = 3'd1,
        KIND_CLOSE  = 3'd2,
        KIND_STRING = 3'd3,
        KIND_NUMBER = 3'd4,
        KIND_SYMBOL = 3'd5,
        KIND_ERROR  = 3'd6,
        KIND_SIGN   = 3'd7
    } kind_t;

    // Character codes used by the lexer.
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Which records one character produces.
    typedef struct packed {
        logic first;   // the superseded token
        logic second;  // the closing token on the final character
    } emit_flags_t;

    // Output queue status seen by the top level.
    typedef struct packed {
        logic room;     // space for two more records
        logic pending;  // at least one record waiting
    } queue_status_t;

    // Code reported for a token: a lone sign is reported as a symbol.
    function automatic logic [2:0] report_kind(kind_t k);
        logic [2:0] r;
        r = (k == KIND_SIGN) ? KIND_SYMBOL : k;
        return r;
    endfunction

endpackage

// ===== hdl/sexpr_lex_if.sv =====
// Valid/ready channel interfaces for the s-expression token lexer.
// Depends on nothing; the character channel and the token channel.
interface sexpr_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       final_char;

    modport source (output valid, output ch, output final_char, input ready);
    modport sink   (input valid, input ch, input final_char, output ready);
endinterface

interface sexpr_token_if #(
    parameter int POS_BITS   = 16,
    parameter int DEPTH_BITS = 8
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   token_kind;
    logic [POS_BITS-1:0]          token_start;
    logic signed [POS_BITS:0]     token_length;
    logic signed [DEPTH_BITS-1:0] nesting_depth;
    logic                         text_done;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output nesting_depth, output text_done,
                    input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input nesting_depth, input text_done,
                    output ready);
endinterface

// ===== hdl/sexpr_lex_core.sv =====
// Lexer state and the per-character update: open token, depth, position.
// Depends on sexpr_lex_pkg for token codes, character codes and flag types.
module sexpr_lex_core
    import sexpr_lex_pkg::*;
#(
    parameter int POS_BITS   = 16,
    parameter int DEPTH_BITS = 8,
    localparam int REC_W     = 3 + POS_BITS + POS_BITS + 1 + DEPTH_BITS + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       ch,
    input  logic             final_char,
    output logic [REC_W-1:0] rec_first,
    output logic [REC_W-1:0] rec_second,
    output emit_flags_t      flags
);

    localparam logic [POS_BITS-1:0]   POS_MAX  = '1;
    localparam logic [POS_BITS-1:0]   POS_ONE  = {{(POS_BITS-1){1'b0}}, 1'b1};
    localparam logic [POS_BITS:0]     LEN_ONE  = {{POS_BITS{1'b0}}, 1'b1};
    localparam logic [POS_BITS:0]     LEN_NEG  = '1;
    localparam logic [DEPTH_BITS-1:0] DEP_ONE  = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
    localparam logic [DEPTH_BITS-1:0] DEP_HI   = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic [DEPTH_BITS-1:0] DEP_LO   = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    kind_t                 kind_reg, kind_next;
    logic [POS_BITS-1:0]   start_reg, start_next;
    logic [POS_BITS:0]     len_reg, len_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;

    logic                  is_ws, is_digit, is_sign, ends_token;
    logic [POS_BITS:0]     len_inc;
    logic [DEPTH_BITS-1:0] depth_up, depth_down;
    kind_t                 new_kind;
    logic [POS_BITS-1:0]   new_start;
    logic [POS_BITS:0]     new_len;
    logic [DEPTH_BITS-1:0] new_depth;
    logic                  emit_first;

    // Character classes.
    assign is_ws      = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_sign    = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign ends_token = is_ws || (ch == CH_RPAREN);

    // Saturating length step; an unterminated-string length restarts at one.
    assign len_inc = len_reg[POS_BITS] ? LEN_ONE :
                     (len_reg[POS_BITS-1:0] != POS_MAX) ? len_reg + LEN_ONE : len_reg;

    // Saturating depth steps.
    assign depth_up   = (depth_reg == DEP_HI) ? depth_reg : depth_reg + DEP_ONE;
    assign depth_down = (depth_reg == DEP_LO) ? depth_reg : depth_reg - DEP_ONE;

    // Token opened by this character from the blank state.
    always_comb
    begin
        new_start = pos_reg;
        new_len   = '0;
        new_depth = depth_reg;
        if (is_ws)
        begin
            new_kind = KIND_BLANK;
        end
        else if (ch == CH_LPAREN)
        begin
            new_kind  = KIND_OPEN;
            new_depth = depth_up;
        end
        else if (ch == CH_RPAREN)
        begin
            new_kind  = KIND_CLOSE;
            new_depth = depth_down;
        end
        else if (ch == CH_QUOTE)
        begin
            new_kind  = KIND_STRING;
            new_start = (pos_reg != POS_MAX) ? pos_reg + POS_ONE : POS_MAX;
            new_len   = LEN_NEG;
        end
        else if (is_digit)
        begin
            new_kind = KIND_NUMBER;
            new_len  = LEN_ONE;
        end
        else if (is_sign)
        begin
            new_kind = KIND_SIGN;
            new_len  = LEN_ONE;
        end
        else
        begin
            new_kind = KIND_SYMBOL;
            new_len  = LEN_ONE;
        end
    end

    // Next open token, and whether the current one is superseded.
    always_comb
    begin
        kind_next  = kind_reg;
        start_next = start_reg;
        len_next   = len_reg;
        depth_next = depth_reg;
        emit_first = 1'b0;
        case (kind_reg)
            KIND_BLANK:
            begin
                kind_next  = new_kind;
                start_next = new_start;
                len_next   = new_len;
                depth_next = new_depth;
            end
            KIND_OPEN, KIND_CLOSE:
            begin
                emit_first = 1'b1;
                kind_next  = new_kind;
                start_next = new_start;
                len_next   = new_len;
                depth_next = new_depth;
            end
            KIND_STRING:
            begin
                if (len_reg[POS_BITS])
                begin
                    // Open string: the closing quote fixes the length.
                    if (ch == CH_QUOTE)
                    begin
                        len_next = (pos_reg >= start_reg) ?
                                   {1'b0, pos_reg - start_reg} : '0;
                    end
                end
                else
                begin
                    emit_first = 1'b1;
                    if (ends_token)
                    begin
                        kind_next  = new_kind;
                        start_next = new_start;
                        len_next   = new_len;
                        depth_next = new_depth;
                    end
                    else
                    begin
                        // Junk after a closed string opens a sticky error.
                        kind_next  = KIND_ERROR;
                        start_next = pos_reg;
                        len_next   = '0;
                    end
                end
            end
            KIND_SIGN:
            begin
                if (is_digit)
                begin
                    kind_next = KIND_NUMBER;
                    len_next  = len_inc;
                end
                else if (ends_token)
                begin
                    emit_first = 1'b1;
                    kind_next  = new_kind;
                    start_next = new_start;
                    len_next   = new_len;
                    depth_next = new_depth;
                end
                else
                begin
                    kind_next = KIND_SYMBOL;
                    len_next  = len_inc;
                end
            end
            KIND_NUMBER, KIND_SYMBOL:
            begin
                if (ends_token)
                begin
                    emit_first = 1'b1;
                    kind_next  = new_kind;
                    start_next = new_start;
                    len_next   = new_len;
                    depth_next = new_depth;
                end
                else
                begin
                    len_next = len_inc;
                    if (!is_digit)
                    begin
                        kind_next = KIND_SYMBOL;
                    end
                end
            end
            default:
            begin
                // The error token ignores everything until the final character.
            end
        endcase
    end

    assign flags.first  = emit_first;
    assign flags.second = final_char;
    assign pos_next     = (pos_reg != POS_MAX) ? pos_reg + POS_ONE : POS_MAX;

    // Records: the superseded token, and the token left open after this character.
    assign rec_first  = {report_kind(kind_reg), start_reg, len_reg, depth_reg, 1'b0};
    assign rec_second = {report_kind(kind_next), start_next, len_next, depth_next, 1'b1};

    // State update; the final character restarts the text.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_BLANK;
            start_reg <= '0;
            len_reg   <= '0;
            depth_reg <= '0;
            pos_reg   <= '0;
        end
        else if (fire)
        begin
            if (final_char)
            begin
                kind_reg  <= KIND_BLANK;
                start_reg <= '0;
                len_reg   <= '0;
                depth_reg <= '0;
                pos_reg   <= '0;
            end
            else
            begin
                kind_reg  <= kind_next;
                start_reg <= start_next;
                len_reg   <= len_next;
                depth_reg <= depth_next;
                pos_reg   <= pos_next;
            end
        end
    end

endmodule

// ===== hdl/sexpr_lex_fifo.sv =====
// Four-entry token record queue that takes up to two records a cycle.
// Depends on sexpr_lex_pkg for the queue status type.
module sexpr_lex_fifo
    import sexpr_lex_pkg::*;
#(
    parameter int WIDTH = 46
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_first,
    input  logic             push_second,
    input  logic [WIDTH-1:0] din_first,
    input  logic [WIDTH-1:0] din_second,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output queue_status_t    status
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_second;
    logic [CNT_W-1:0] pushes;
    logic             do_pop;

    assign pushes     = CNT_W'(push_first) + CNT_W'(push_second);
    assign do_pop     = pop && (count_reg != '0);
    assign count_next = count_reg + pushes - CNT_W'(do_pop);
    assign wr_second  = push_first ? wr_reg + PTR_W'(1) : wr_reg;

    assign dout           = mem[rd_reg];
    assign status.pending = (count_reg != '0);
    assign status.room    = (count_reg <= CNT_W'(DEPTH - 2));

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (push_first)
        begin
            mem[wr_reg] <= din_first;
        end
        if (push_second)
        begin
            mem[wr_second] <= din_second;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_reg + PTR_W'(pushes);
            rd_reg    <= rd_reg + PTR_W'(do_pop);
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/sexpr_token_lexer_unit.sv =====
// Top level of the s-expression token lexer: input register, lexer core, record queue.
// Depends on sexpr_lex_pkg, sexpr_lex_if, sexpr_lex_core and sexpr_lex_fifo.
//
// The lexer takes one character word per cycle on char_stream, while the queue has
// room, and delivers token record words on token_stream. A character is held in an
// input register and is processed once the four-entry record queue has space for two
// records; its records are written into the queue and offered on token_stream.
// A character yields zero, one or two records (two when a token ends on the final
// character); token_stream gives one record per cycle while ready. The sustained rate
// is one character per cycle while characters yield at most one record each, and the
// record output bounds it otherwise. Position (POS_BITS) and token length (POS_BITS+1)
// saturate; the nesting depth is DEPTH_BITS wide, signed and saturating.
module sexpr_token_lexer_unit
    import sexpr_lex_pkg::*;
#(
    parameter int POS_BITS   = 16,
    parameter int DEPTH_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    sexpr_char_if.sink    char_stream,
    sexpr_token_if.source token_stream
);

    localparam int REC_W = 3 + POS_BITS + POS_BITS + 1 + DEPTH_BITS + 1;

    logic             in_valid_reg;
    logic [7:0]       in_ch_reg;
    logic             in_final_reg;
    logic             fire;
    logic [REC_W-1:0] rec_first, rec_second, rec_out;
    emit_flags_t      flags;
    queue_status_t    status;

    // A registered character is processed once the queue can take two records.
    assign fire              = in_valid_reg && status.room;
    assign char_stream.ready = !in_valid_reg || fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (char_stream.ready)
        begin
            in_valid_reg <= char_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_stream.ready && char_stream.valid)
        begin
            in_ch_reg    <= char_stream.ch;
            in_final_reg <= char_stream.final_char;
        end
    end

    sexpr_lex_core #(
        .POS_BITS   (POS_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .ch         (in_ch_reg),
        .final_char (in_final_reg),
        .rec_first  (rec_first),
        .rec_second (rec_second),
        .flags      (flags)
    );

    sexpr_lex_fifo #(
        .WIDTH (REC_W)
    ) u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_first  (fire && flags.first),
        .push_second (fire && flags.second),
        .din_first   (rec_first),
        .din_second  (rec_second),
        .pop         (token_stream.ready),
        .dout        (rec_out),
        .status      (status)
    );

    // Unpack the head record onto the token channel.
    assign token_stream.valid         = status.pending;
    assign token_stream.token_kind    = rec_out[REC_W-1 -: 3];
    assign token_stream.token_start   = rec_out[REC_W-4 -: POS_BITS];
    assign token_stream.token_length  = rec_out[DEPTH_BITS+1 +: POS_BITS+1];
    assign token_stream.nesting_depth = rec_out[1 +: DEPTH_BITS];
    assign token_stream.text_done     = rec_out[0];

    // A registered character that cannot be processed is kept.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_ch_reg)))
        else $error("stalled character lost");

    // The final character always produces its closing record.
    a_final_record: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_final_reg) |-> flags.second)
        else $error("final character produced no closing record");

    // The internal sign code never leaves the block.
    a_no_sign_kind: assert property (@(posedge clk) disable iff (!rst_n)
        token_stream.valid |-> (token_stream.token_kind != KIND_SIGN))
        else $error("lone sign reported with internal code");

    // A record written into the queue is offered on the next cycle.
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (flags.first || flags.second)) |=> status.pending)
        else $error("queue empty after a record was written");

endmodule
